FILE: src/lcdc_pkg.sv
// ============================================================================
// lcdc_pkg
// Shared types and constants for the LCD controller: store geometry, command
// decode masks, step directions and the controller/datapath handshake structs.
// ============================================================================
package lcdc_pkg;

    // Store geometry defaults
    localparam int ROW_BYTES_DEF   = 12;
    localparam int STORE_BYTES_DEF = 768;
    localparam int ROWS            = 64;
    localparam int ROW_W           = 6;
    localparam int COL_W           = 5;
    localparam int COL_WRAP_W      = 4;

    // Command byte decode
    localparam logic [7:0] CMD_MODE_MASK  = 8'hFE;
    localparam logic [7:0] CMD_MODE_CODE  = 8'h00;
    localparam logic [7:0] CMD_DIR_MASK   = 8'hFC;
    localparam logic [7:0] CMD_DIR_CODE   = 8'h04;
    localparam logic [7:0] CMD_GRP2_MASK  = 8'hC0;
    localparam logic [7:0] CMD_SCRL_CODE  = 8'h40;
    localparam logic [7:0] CMD_ROW_CODE   = 8'h80;
    localparam logic [7:0] CMD_COL_MASK   = 8'hE0;
    localparam logic [7:0] CMD_COL_CODE   = 8'h20;

    // Read results with no store access
    localparam logic [7:0] CMD_READ_VALUE = 8'hFF;
    localparam logic [7:0] ZERO_VALUE     = 8'h00;

    // Six-bit pixel field, aligned to bits 7..2
    localparam logic [7:0] PIX_MASK       = 8'hFC;
    localparam logic [3:0] SIX_RD_SHIFT   = 4'd10;
    localparam logic [3:0] BYTE_BITS      = 4'd8;

    typedef enum logic [1:0] {
        DIR_ROW_DEC = 2'd0,
        DIR_ROW_INC = 2'd1,
        DIR_COL_DEC = 2'd2,
        DIR_COL_INC = 2'd3
    } lcdc_dir_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;       // latch incoming word and its store address
        logic clr;        // clear one store byte
        logic exec_cmd;   // apply command write
        logic clr_dummy;  // consume armed dummy read
        logic step;       // advance cursor
        logic rd_lo;      // read first byte
        logic rd_hi;      // read second byte
        logic cap_lo;     // capture first byte
        logic cap_hi;     // capture second byte
        logic wr_lo;      // write first byte
        logic wr_hi;      // write second byte
        logic push;       // load result into output stage
    } lcdc_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic is_write;
        logic is_data;
        logic byte_mode;
        logic dummy;
        logic straddle;
        logic out_busy;
        logic clr_last;
    } lcdc_stat_t;

endpackage

FILE: src/lcdc_ctrl.sv
// ============================================================================
// lcdc_ctrl
// Sequencer for the LCD controller: store clearing pass, then one access at a
// time through read, capture, merge and write steps.
// ============================================================================
module lcdc_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  lcdc_pkg::lcdc_stat_t stat,
    output lcdc_pkg::lcdc_cmd_t  cmd
);
    import lcdc_pkg::*;

    typedef enum logic [8:0] {
        ST_CLEAR    = 9'b000000001,
        ST_IDLE     = 9'b000000010,
        ST_DISPATCH = 9'b000000100,
        ST_CAP_LO   = 9'b000001000,
        ST_RD_HI    = 9'b000010000,
        ST_CAP_HI   = 9'b000100000,
        ST_MERGE_LO = 9'b001000000,
        ST_MERGE_HI = 9'b010000000,
        ST_FINISH   = 9'b100000000
    } lcdc_state_t;

    lcdc_state_t state_reg;
    lcdc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (!stat.is_data)
                begin
                    cmd.exec_cmd = stat.is_write;
                    state_next   = ST_FINISH;
                end
                else if (!stat.is_write && stat.dummy)
                begin
                    cmd.clr_dummy = 1'b1;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    // address is latched, so the cursor can move now
                    cmd.step = 1'b1;
                    if (stat.byte_mode && stat.is_write)
                    begin
                        cmd.wr_lo  = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cmd.rd_lo = 1'b1;
                        if (stat.byte_mode)
                        begin
                            state_next = ST_CAP_LO;
                        end
                        else if (stat.is_write)
                        begin
                            state_next = ST_MERGE_LO;
                        end
                        else
                        begin
                            state_next = ST_RD_HI;
                        end
                    end
                end
            end
            ST_CAP_LO:
            begin
                cmd.cap_lo = 1'b1;
                state_next = ST_FINISH;
            end
            ST_RD_HI:
            begin
                cmd.cap_lo = 1'b1;
                cmd.rd_hi  = 1'b1;
                state_next = ST_CAP_HI;
            end
            ST_CAP_HI:
            begin
                cmd.cap_hi = 1'b1;
                state_next = ST_FINISH;
            end
            ST_MERGE_LO:
            begin
                cmd.wr_lo = 1'b1;
                if (stat.straddle)
                begin
                    cmd.rd_hi  = 1'b1;
                    state_next = ST_MERGE_HI;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_MERGE_HI:
            begin
                cmd.wr_hi  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

FILE: src/lcdc_dp.sv
// ============================================================================
// lcdc_dp
// Datapath of the LCD controller: cursor and mode registers, frame store,
// six-bit merge and extract logic, and the output word register.
// ============================================================================
module lcdc_dp
#(
    parameter int ROW_BYTES   = lcdc_pkg::ROW_BYTES_DEF,
    parameter int STORE_BYTES = lcdc_pkg::STORE_BYTES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           s_axis_tdata,
    input  logic [1:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,
    input  lcdc_pkg::lcdc_cmd_t  cmd,
    output lcdc_pkg::lcdc_stat_t stat
);
    import lcdc_pkg::*;

    localparam int MEM_AW = $clog2(STORE_BYTES);
    // widest address: last row plus a five-bit column in byte mode
    localparam int ADDR_W = $clog2((ROWS - 1) * ROW_BYTES + (1 << COL_W));
    localparam int CMP_W  = (ADDR_W > MEM_AW) ? ADDR_W + 1 : MEM_AW + 1;

    logic [7:0] mem [STORE_BYTES];

    // cursor and mode
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             mode_reg, mode_next;
    lcdc_dir_t        dir_reg, dir_next;
    logic             pend_reg, pend_next;

    // latched word
    logic              item_wr_reg;
    logic              item_data_reg;
    logic              item_mode_reg;
    logic              item_dummy_reg;
    logic [7:0]        value_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [2:0]        off_reg;

    logic [MEM_AW-1:0] clr_cnt_reg;
    logic [7:0]        rdata_reg;
    logic              rd_ok_reg;
    logic [7:0]        b0_reg;
    logic [7:0]        b1_reg;
    logic              out_valid_reg;
    logic [7:0]        out_data_reg;

    logic [7:0]        pos;
    logic [ADDR_W-1:0] addr_cur;
    logic [ADDR_W-1:0] addr_hi;
    logic              lo_ok;
    logic              hi_ok;
    logic [7:0]        rd_byte;
    logic [7:0]        pix;
    logic [3:0]        back;
    logic [7:0]        merge_lo;
    logic [7:0]        merge_hi;
    logic [15:0]       six_word;
    logic [3:0]        six_shamt;
    logic [7:0]        result;
    logic [COL_W-1:0]  col_step;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              rd_en;
    logic              rd_ok;
    logic [MEM_AW-1:0] mem_raddr;

    // ---- store address of the current cursor
    assign pos      = 8'(col_reg) * 8'd6;
    assign addr_cur = ADDR_W'(row_reg) * ADDR_W'(ROW_BYTES)
                    + (mode_reg ? ADDR_W'(col_reg) : ADDR_W'(pos[7:3]));
    assign addr_hi  = addr_reg + ADDR_W'(1);
    assign lo_ok    = CMP_W'(addr_reg) < CMP_W'(STORE_BYTES);
    assign hi_ok    = CMP_W'(addr_hi) < CMP_W'(STORE_BYTES);

    // ---- merge and extract
    assign rd_byte   = rd_ok_reg ? rdata_reg : ZERO_VALUE;
    assign pix       = {value_reg[5:0], 2'b00};
    assign back      = BYTE_BITS - {1'b0, off_reg};
    assign merge_lo  = (rd_byte & ~(PIX_MASK >> off_reg)) | (pix >> off_reg);
    assign merge_hi  = (rd_byte & ~(8'({8'h00, PIX_MASK} << back)))
                     | 8'({8'h00, pix} << back);
    assign six_word  = {b0_reg, b1_reg};
    assign six_shamt = SIX_RD_SHIFT - {1'b0, off_reg};

    always_comb
    begin
        if (!item_data_reg)
        begin
            result = item_wr_reg ? ZERO_VALUE : CMD_READ_VALUE;
        end
        else if (item_wr_reg || item_dummy_reg)
        begin
            result = ZERO_VALUE;
        end
        else if (item_mode_reg)
        begin
            result = b0_reg;
        end
        else
        begin
            result = 8'(six_word >> six_shamt);
        end
    end

    // ---- cursor, mode and command decode
    assign col_step = (dir_reg == DIR_COL_DEC) ? col_reg - COL_W'(1) : col_reg + COL_W'(1);

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        mode_next = mode_reg;
        dir_next  = dir_reg;
        pend_next = pend_reg;
        if (cmd.exec_cmd)
        begin
            if ((value_reg & CMD_MODE_MASK) == CMD_MODE_CODE)
            begin
                mode_next = value_reg[0];
            end
            else if ((value_reg & CMD_DIR_MASK) == CMD_DIR_CODE)
            begin
                dir_next = lcdc_dir_t'(value_reg[1:0]);
            end
            else if ((value_reg & CMD_GRP2_MASK) == CMD_SCRL_CODE)
            begin
                // scroll offset not kept
                pend_next = pend_reg;
            end
            else if ((value_reg & CMD_COL_MASK) == CMD_COL_CODE)
            begin
                col_next  = value_reg[COL_W-1:0];
                pend_next = 1'b1;
            end
            else if ((value_reg & CMD_GRP2_MASK) == CMD_ROW_CODE)
            begin
                row_next  = value_reg[ROW_W-1:0];
                pend_next = 1'b1;
            end
        end
        if (cmd.clr_dummy)
        begin
            pend_next = 1'b0;
        end
        if (cmd.step)
        begin
            // column wraps to four bits on every step
            col_next = {1'b0, col_reg[COL_WRAP_W-1:0]};
            unique case (dir_reg)
                DIR_ROW_DEC: row_next = row_reg - ROW_W'(1);
                DIR_ROW_INC: row_next = row_reg + ROW_W'(1);
                DIR_COL_DEC,
                DIR_COL_INC: col_next = {1'b0, col_step[COL_WRAP_W-1:0]};
                default:     row_next = row_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            mode_reg      <= 1'b0;
            dir_reg       <= DIR_ROW_DEC;
            pend_reg      <= 1'b0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            mode_reg <= mode_next;
            dir_reg  <= dir_next;
            pend_reg <= pend_next;
            if (cmd.clr)
            begin
                clr_cnt_reg <= clr_cnt_reg + MEM_AW'(1);
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---- latched word and captured bytes
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_wr_reg    <= s_axis_tuser[0];
            item_data_reg  <= s_axis_tuser[1];
            item_mode_reg  <= mode_reg;
            item_dummy_reg <= pend_reg;
            value_reg      <= s_axis_tdata;
            addr_reg       <= addr_cur;
            off_reg        <= pos[2:0];
        end
        if (cmd.cap_lo)
        begin
            b0_reg <= rd_byte;
        end
        if (cmd.cap_hi)
        begin
            b1_reg <= rd_byte;
        end
        if (cmd.push)
        begin
            out_data_reg <= result;
        end
    end

    // ---- frame store
    assign mem_we    = cmd.clr || (cmd.wr_lo && lo_ok) || (cmd.wr_hi && hi_ok);
    assign mem_waddr = cmd.clr ? clr_cnt_reg
                     : (cmd.wr_hi ? MEM_AW'(addr_hi) : MEM_AW'(addr_reg));
    assign mem_wdata = cmd.clr ? ZERO_VALUE
                     : (cmd.wr_hi ? merge_hi : (item_mode_reg ? value_reg : merge_lo));
    assign rd_en     = cmd.rd_lo || cmd.rd_hi;
    assign rd_ok     = cmd.rd_hi ? hi_ok : lo_ok;
    assign mem_raddr = cmd.rd_hi ? MEM_AW'(addr_hi) : MEM_AW'(addr_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_ok_reg <= rd_ok;
            if (rd_ok)
            begin
                rdata_reg <= mem[mem_raddr];
            end
        end
    end

    // ---- status
    assign stat.is_write  = item_wr_reg;
    assign stat.is_data   = item_data_reg;
    assign stat.byte_mode = item_mode_reg;
    assign stat.dummy     = item_dummy_reg;
    assign stat.straddle  = off_reg[2];
    assign stat.out_busy  = out_valid_reg && !m_axis_tready;
    assign stat.clr_last  = clr_cnt_reg == MEM_AW'(STORE_BYTES - 1);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

FILE: src/lcd_controller_ports.sv
// ============================================================================
// lcd_controller_ports
// Monochrome LCD controller with command and data ports over a byte-wide
// frame store (ROWS rows of ROW_BYTES bytes), byte or six-bit word access.
// ============================================================================
//
//  channel   dir  handshake                    payload
//  --------  ---  ---------------------------  -------------------------------
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser: opcode, register_select
//                                              tdata: write_value
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: read_data
//
//  One word in gives one word out, in order.
//  Each word passes idle, dispatch and finish. A command access, dummy read
//  or byte write needs no more; a byte read adds a capture step, a six-bit
//  write a merge step (two if it straddles two bytes), and a six-bit read a
//  second-byte read step and a capture step. The store has a registered read
//  port, one byte read per cycle; a straddling six-bit write reads its second
//  byte in the same cycle that it writes the first. After reset a clearing
//  pass writes zero to every store byte, with s_axis_tready low.
//  A stalled output word holds in the output register; the sequencer waits in
//  its last step until that register is free, so at most one more word is
//  taken in meanwhile.
//
module lcd_controller_ports
#(
    parameter int ROW_BYTES   = lcdc_pkg::ROW_BYTES_DEF,
    parameter int STORE_BYTES = lcdc_pkg::STORE_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] write_value
    input  logic [1:0] s_axis_tuser,   // [0] opcode (1 write), [1] register_select (1 data)
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [7:0] read_data
);
    import lcdc_pkg::*;

    lcdc_cmd_t  cmd;    // sequencer step commands
    lcdc_stat_t stat;   // latched word kind, mode, dummy and straddle flags, output and clear status

    lcdc_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    lcdc_dp
    #(
        .ROW_BYTES   (ROW_BYTES),
        .STORE_BYTES (STORE_BYTES)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

FILE: src/lcdc_checker.sv
// ============================================================================
// lcdc_checker
// Port-level checks for the LCD controller, bound to the top level.
// ============================================================================
module lcdc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // after a word is taken, s_axis_tready stays low through dispatch and the step after it
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input taken while previous word in flight");

    // a new output word is only loaded from the final step, never from idle
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("output word appeared without a finished access");

endmodule

bind lcd_controller_ports lcdc_checker u_lcdc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
